// File: hdl/track_odometry_arm_angle_filter_core_assert.svh
// Assertion macros for the track odometry and arm angle filter.
// Included by the top level; no other dependencies.
`ifndef TRACK_ODOMETRY_ARM_ANGLE_FILTER_CORE_ASSERT_SVH
`define TRACK_ODOMETRY_ARM_ANGLE_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define TAOF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("track filter check failed");
// Next-cycle implication under reset.
`define TAOF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("track filter check failed");
`else
`define TAOF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TAOF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/taof_pkg.sv
// Shared types, widths and constants of the track odometry and arm angle filter.
// No dependencies.
package taof_pkg;

    // Command codes of an input transaction.
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;
    localparam logic [1:0] CMD_ARM    = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_PER_DEG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEG_PER_RAW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_FLOOR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_CEIL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT  = 3'd7;

    // Field widths.
    localparam int TRACK_W      = 48;
    localparam int ANGLE_W      = 24;
    localparam int RAW_W        = 16;
    localparam int SCALE_W      = 32;
    localparam int GAIN_W       = 16;
    localparam int STEP_W       = 23;
    localparam int ANGLE_PROD_W = 33;
    localparam int CMD_PROD_W   = 40;

    // Saturation limits.
    localparam logic signed [TRACK_W-1:0] TRACK_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [TRACK_W-1:0] TRACK_MIN = 48'sh8000_0000_0000;
    localparam logic signed [RAW_W-1:0]   RAW_MAX   = 16'sh7FFF;
    localparam logic signed [RAW_W-1:0]   RAW_MIN   = 16'sh8000;

    // Configuration reset values.
    localparam logic signed [GAIN_W-1:0]  GAIN_RESET  = 16'sd256;
    localparam logic signed [ANGLE_W-1:0] FLOOR_RESET = -24'sd23040;
    localparam logic signed [ANGLE_W-1:0] CEIL_RESET  = 24'sd23040;
    localparam logic [STEP_W-1:0]         STEP_RESET  = 23'd2560;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [RAW_W-1:0]  clicks_left;
        logic signed [RAW_W-1:0]  clicks_right;
        logic signed [RAW_W-1:0]  raw_inclination;
        logic signed [RAW_W-1:0]  target_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [TRACK_W-1:0] odo_left;
        logic signed [TRACK_W-1:0] odo_right;
        logic signed [ANGLE_W-1:0] held_pitch;
        logic                      sample_accepted;
        logic signed [RAW_W-1:0]   raw_command;
        logic                      command_valid;
    } t_out_item;

    typedef struct packed {
        logic [SCALE_W-1:0]        left_click_scale;
        logic [SCALE_W-1:0]        right_click_scale;
        logic signed [GAIN_W-1:0]  raw_offset;
        logic signed [GAIN_W-1:0]  raw_per_degree;
        logic signed [GAIN_W-1:0]  degree_per_raw;
        logic signed [ANGLE_W-1:0] angle_floor;
        logic signed [ANGLE_W-1:0] angle_ceiling;
        logic [STEP_W-1:0]         angle_step_limit;
    } t_cfg;

    // Classified work passed from the front to the back.
    typedef struct packed {
        logic [1:0]                     cmd;
        logic signed [TRACK_W-1:0]      dist_left;
        logic signed [TRACK_W-1:0]      dist_right;
        logic signed [ANGLE_PROD_W-1:0] angle_prod;
        logic signed [RAW_W-1:0]        target_angle;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Saturating add of a distance to a track accumulator.
    function automatic logic signed [TRACK_W-1:0] sat_track_add(
        input logic signed [TRACK_W-1:0] a,
        input logic signed [TRACK_W-1:0] b
    );
        logic signed [TRACK_W:0] sum;
        sum = {a[TRACK_W-1], a} + {b[TRACK_W-1], b};
        if (sum[TRACK_W] != sum[TRACK_W-1]) begin
            return sum[TRACK_W] ? TRACK_MIN : TRACK_MAX;
        end
        return sum[TRACK_W-1:0];
    endfunction

endpackage

// File: hdl/taof_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
// The payload type is given by the instance; no package dependency.
interface taof_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/taof_front.sv
// Front part: registers an input transaction and forms the click and angle products.
// Depends on taof_pkg and taof_stream_if.
module taof_front import taof_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    taof_stream_if.sink   i_item,
    output logic          o_push,
    output t_work         o_work,
    input  logic          i_full
);

    logic     r_valid;
    t_in_item r_item;

    logic signed [SCALE_W+RAW_W:0]  w_prod_l;
    logic signed [SCALE_W+RAW_W:0]  w_prod_r;
    logic signed [RAW_W:0]          w_raw_diff;

    // The stage takes a new transaction when empty or when it moves on.
    assign o_push       = r_valid && !i_full;
    assign i_item.ready = !r_valid || !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_item <= i_item.payload;
        end
    end

    // Distance per wheel: signed clicks times unsigned scale.
    assign w_prod_l = $signed(r_item.clicks_left) * $signed({1'b0, i_cfg.left_click_scale});
    assign w_prod_r = $signed(r_item.clicks_right) * $signed({1'b0, i_cfg.right_click_scale});

    // Angle before limiting: (raw - offset) * degrees per raw unit, exact in Q.8.
    assign w_raw_diff = $signed({r_item.raw_inclination[RAW_W-1], r_item.raw_inclination})
                      - $signed({i_cfg.raw_offset[GAIN_W-1], i_cfg.raw_offset});

    always_comb begin
        o_work.cmd          = r_item.cmd;
        o_work.dist_left    = w_prod_l[TRACK_W-1:0];
        o_work.dist_right   = w_prod_r[TRACK_W-1:0];
        o_work.angle_prod   = w_raw_diff * i_cfg.degree_per_raw;
        o_work.target_angle = r_item.target_angle;
    end

endmodule

// File: hdl/taof_queue.sv
// Short first-in first-out queue of classified work between front and back.
// Depends on taof_pkg.
module taof_queue import taof_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_work         i_work,
    input  logic          i_pop,
    output t_work         o_head,
    output t_queue_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work            r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_head         = r_slot[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_work;
        end
    end

endmodule

// File: hdl/taof_back.sv
// Back part: updates tracks and held angle, forms raw commands, drives results.
// Depends on taof_pkg and taof_stream_if.
module taof_back import taof_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_work         i_head,
    input  t_queue_status i_status,
    output logic          o_pop,
    taof_stream_if.source o_res
);

    // State.
    logic signed [TRACK_W-1:0] r_left;
    logic signed [TRACK_W-1:0] r_right;
    logic signed [ANGLE_W-1:0] r_held;
    logic signed [TRACK_W-1:0] n_left;
    logic signed [TRACK_W-1:0] n_right;
    logic signed [ANGLE_W-1:0] n_held;

    // Stage A: state applied.
    logic                      r_a_valid;
    logic signed [TRACK_W-1:0] r_a_left;
    logic signed [TRACK_W-1:0] r_a_right;
    logic signed [ANGLE_W-1:0] r_a_angle;
    logic                      r_a_accepted;
    logic                      r_a_cmd_valid;
    logic signed [ANGLE_W-1:0] r_a_op;

    // Stage B: command product.
    logic                         r_b_valid;
    logic signed [TRACK_W-1:0]    r_b_left;
    logic signed [TRACK_W-1:0]    r_b_right;
    logic signed [ANGLE_W-1:0]    r_b_angle;
    logic                         r_b_accepted;
    logic                         r_b_cmd_valid;
    logic signed [CMD_PROD_W-1:0] r_b_prod;

    // Stage C: result register.
    logic      r_c_valid;
    t_out_item r_c_item;

    logic                           w_en;
    logic                           w_in_range;
    logic signed [ANGLE_W:0]        w_step;
    logic [ANGLE_W:0]               w_step_abs;
    logic                           w_accept;
    logic signed [ANGLE_W-1:0]      w_op;
    logic signed [CMD_PROD_W:0]     w_scaled;
    logic signed [CMD_PROD_W-16:0]  w_quot;
    logic signed [RAW_W-1:0]        w_raw_sat;

    // The whole back pipeline moves unless a finished result is stalled.
    assign w_en  = !r_c_valid || o_res.ready;
    assign o_pop = w_en && !i_status.empty;

    // Plausibility checks: a product outside 24 bits always fails the range test.
    assign w_in_range = (i_head.angle_prod > ANGLE_PROD_W'(i_cfg.angle_floor))
                     && (i_head.angle_prod < ANGLE_PROD_W'(i_cfg.angle_ceiling));
    assign w_step     = $signed({i_head.angle_prod[ANGLE_W-1], i_head.angle_prod[ANGLE_W-1:0]})
                      - $signed({r_held[ANGLE_W-1], r_held});
    assign w_step_abs = w_step[ANGLE_W] ? -w_step : w_step;
    assign w_accept   = (i_head.cmd == CMD_SAMPLE) && w_in_range
                     && (w_step_abs < {2'b00, i_cfg.angle_step_limit});

    // Next state per command.
    always_comb begin
        n_left  = r_left;
        n_right = r_right;
        n_held  = w_accept ? i_head.angle_prod[ANGLE_W-1:0] : r_held;
        unique case (i_head.cmd)
            CMD_SAMPLE: begin
                n_left  = sat_track_add(r_left, i_head.dist_left);
                n_right = sat_track_add(r_right, i_head.dist_right);
            end
            CMD_CLEAR: begin
                n_left  = '0;
                n_right = '0;
            end
            CMD_STOP, CMD_ARM: begin
                n_left  = r_left;
                n_right = r_right;
            end
            default: begin
                n_left  = r_left;
                n_right = r_right;
            end
        endcase
    end

    // Multiplier operand in Q.8: held angle for stop, whole degrees shifted for arm.
    assign w_op = (i_head.cmd == CMD_STOP) ? r_held : {i_head.target_angle, 8'h00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
            r_held  <= '0;
        end else if (o_pop) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_held  <= n_held;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= o_pop;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Stage A payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_left      <= n_left;
            r_a_right     <= n_right;
            r_a_angle     <= n_held;
            r_a_accepted  <= w_accept;
            r_a_cmd_valid <= (i_head.cmd == CMD_STOP) || (i_head.cmd == CMD_ARM);
            r_a_op        <= w_op;
        end
    end

    // Stage B payload: operand times raw units per degree, Q.16.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_left      <= r_a_left;
            r_b_right     <= r_a_right;
            r_b_angle     <= r_a_angle;
            r_b_accepted  <= r_a_accepted;
            r_b_cmd_valid <= r_a_cmd_valid;
            r_b_prod      <= r_a_op * i_cfg.raw_per_degree;
        end
    end

    // Add the offset, drop the fraction toward zero and saturate to 16 bits.
    assign w_scaled = {r_b_prod[CMD_PROD_W-1], r_b_prod}
                    + (CMD_PROD_W+1)'($signed({i_cfg.raw_offset, 16'h0000}));
    assign w_quot   = w_scaled[CMD_PROD_W:16]
                    + {{(CMD_PROD_W-16){1'b0}}, (w_scaled[CMD_PROD_W] && (|w_scaled[15:0]))};

    always_comb begin
        if (w_quot > (CMD_PROD_W-15)'(RAW_MAX)) begin
            w_raw_sat = RAW_MAX;
        end else if (w_quot < (CMD_PROD_W-15)'(RAW_MIN)) begin
            w_raw_sat = RAW_MIN;
        end else begin
            w_raw_sat = w_quot[RAW_W-1:0];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_item.odo_left        <= r_b_left;
            r_c_item.odo_right       <= r_b_right;
            r_c_item.held_pitch      <= r_b_angle;
            r_c_item.sample_accepted <= r_b_accepted;
            r_c_item.raw_command     <= r_b_cmd_valid ? w_raw_sat : '0;
            r_c_item.command_valid   <= r_b_cmd_valid;
        end
    end

    assign o_res.valid   = r_c_valid;
    assign o_res.payload = r_c_item;

endmodule

// File: hdl/track_odometry_arm_angle_filter_core.sv
// Top level of the track odometry and arm angle filter: configuration registers,
// front, queue and back. Depends on taof_pkg, taof_stream_if and the assertion header.
//
// Channel      Direction  Handshake    Payload
// i_in_chan    in         valid/ready  t_in_item  (cmd, clicks, raw reading, target)
// o_out_chan   out        valid/ready  t_out_item (tracks, angle, flags, raw command)
// i_cfg_*      in         write enable register index and 32-bit data
//
// One transaction per cycle is sustained while the output is ready; a result
// passes the front register, queue, state stage, multiplier and result register.
// The front and back stall on their own, the queue absorbs the difference.
// Synchronous reset clears tracks, held angle, queue, valid bits; sets config defaults.
`include "track_odometry_arm_angle_filter_core_assert.svh"
module track_odometry_arm_angle_filter_core import taof_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    taof_stream_if.sink           i_in_chan,
    taof_stream_if.source         o_out_chan,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg          r_cfg;
    logic          w_push;
    logic          w_pop;
    t_work         w_work;
    t_work         w_head;
    t_queue_status w_status;
    t_out_item     w_res;
    logic          w_res_valid;
    logic          w_in_window;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_click_scale  <= '0;
            r_cfg.right_click_scale <= '0;
            r_cfg.raw_offset        <= '0;
            r_cfg.raw_per_degree    <= GAIN_RESET;
            r_cfg.degree_per_raw    <= GAIN_RESET;
            r_cfg.angle_floor       <= FLOOR_RESET;
            r_cfg.angle_ceiling     <= CEIL_RESET;
            r_cfg.angle_step_limit  <= STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEFT_SCALE:  r_cfg.left_click_scale  <= i_cfg_data;
                CFG_RIGHT_SCALE: r_cfg.right_click_scale <= i_cfg_data;
                CFG_RAW_OFFSET:  r_cfg.raw_offset        <= i_cfg_data[GAIN_W-1:0];
                CFG_RAW_PER_DEG: r_cfg.raw_per_degree    <= i_cfg_data[GAIN_W-1:0];
                CFG_DEG_PER_RAW: r_cfg.degree_per_raw    <= i_cfg_data[GAIN_W-1:0];
                CFG_ANGLE_FLOOR: r_cfg.angle_floor       <= i_cfg_data[ANGLE_W-1:0];
                CFG_ANGLE_CEIL:  r_cfg.angle_ceiling     <= i_cfg_data[ANGLE_W-1:0];
                CFG_STEP_LIMIT:  r_cfg.angle_step_limit  <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    taof_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (i_in_chan),
        .o_push  (w_push),
        .o_work  (w_work),
        .i_full  (w_status.full)
    );

    taof_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_work   (w_work),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    taof_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (w_head),
        .i_status (w_status),
        .o_pop    (w_pop),
        .o_res    (o_out_chan)
    );

    // Result view for the checks below.
    assign w_res       = o_out_chan.payload;
    assign w_res_valid = o_out_chan.valid;
    assign w_in_window = (w_res.held_pitch > r_cfg.angle_floor)
                      && (w_res.held_pitch < r_cfg.angle_ceiling);

    // A transaction pushed into the queue leaves it non-empty.
    `TAOF_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, w_push, !w_status.empty)
    // An accepted sample angle lies strictly inside the configured window.
    `TAOF_ASSERT_NOW(a_accept_window, i_clk, i_rst_n, w_res_valid && w_res.sample_accepted, w_in_window)
    // A raw command result is never also an accepted sample.
    `TAOF_ASSERT_NOW(a_cmd_excl, i_clk, i_rst_n, w_res_valid && w_res.command_valid, !w_res.sample_accepted)
    // Results without a command carry a zero raw command.
    `TAOF_ASSERT_NOW(a_raw_zero, i_clk, i_rst_n, w_res_valid && !w_res.command_valid, w_res.raw_command == '0)

endmodule
